// File: rtl/assert_macros.svh
// Assertion shorthands, clocked on clk, quiet while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define NUC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define NUC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/nuc_pkg.sv
package nuc_pkg;

  localparam int unsigned FRAME_COLUMNS = 640;
  localparam int unsigned FRAME_ROWS    = 512;
  localparam int unsigned NPIX          = FRAME_COLUMNS * FRAME_ROWS;
  localparam int unsigned ADDR_W        = $clog2(NPIX);

  localparam int unsigned SUM_W   = 22;
  localparam int unsigned TOT_W   = 41;
  localparam int unsigned GAIN_W  = 16;
  localparam int unsigned OFF_W   = 22;
  localparam int unsigned PIX_W   = 16;
  localparam int unsigned CFG_W   = 7;
  localparam int unsigned QUO_W   = 22;
  localparam int unsigned DIV_W   = 64;
  localparam int unsigned COEF_W  = GAIN_W + OFF_W;
  localparam int unsigned SUMS_W  = 2 * SUM_W;

  localparam logic [SUM_W-1:0]  SUM_LIMIT    = '1;
  localparam logic [GAIN_W-1:0] UNITY_GAIN   = GAIN_W'(4096);
  localparam logic [GAIN_W-1:0] GAIN_MAX     = '1;
  localparam logic [OFF_W-1:0]  OFFSET_HIGH  = {1'b0, {(OFF_W-1){1'b1}}};
  localparam logic [OFF_W-1:0]  OFFSET_LOW   = {1'b1, {(OFF_W-1){1'b0}}};
  localparam logic [CFG_W-1:0]  RESET_FRAMES = CFG_W'(50);

  typedef enum logic [1:0] {
    CMD_HOT     = 2'd0,
    CMD_COLD    = 2'd1,
    CMD_COMPUTE = 2'd2,
    CMD_CORRECT = 2'd3
  } cmd_t;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_CAL   = 1'b1;

endpackage

// File: rtl/nuc_div.sv
// restoring divider, one quotient bit per cycle; needs num < den << QUO_W
module nuc_div
  import nuc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] num,
  input  logic [DIV_W-1:0] den,
  output logic             done,
  output logic [QUO_W-1:0] quo
);

  localparam int unsigned CNT_W = $clog2(QUO_W + 1);

  logic [DIV_W-1:0] rem_r, dsh_r;
  logic [QUO_W-1:0] quo_r;
  logic [CNT_W-1:0] cnt_r;
  logic             run_r, done_r;
  logic             fit;

  assign fit = (rem_r >= dsh_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CNT_W'(QUO_W);
        rem_r <= num;
        dsh_r <= den << (QUO_W - 1);
      end else if (run_r) begin
        if (fit) rem_r <= rem_r - dsh_r;
        quo_r <= {quo_r[QUO_W-2:0], fit};
        dsh_r <= dsh_r >> 1;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// File: rtl/two_point_nonuniformity_correction.sv
// Steps: accumulate runs S_ACC, correct runs S_COR_MUL and S_COR_OUT to out_strobe,
// compute walks all NPIX pixels with up to two 22-bit divides each, none for dead pixels.
// Throughput: one word at a time; busy is high until the word is done and any result issued.
// Reset: synchronous, rst_n low; afterwards a clearing pass over all NPIX (327680) entries
// writes zero sums, unity gain and zero offset, with busy high. The receiver cannot stall.
module two_point_nonuniformity_correction
  import nuc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_command,
  input  logic [ADDR_W-1:0] in_pixel_index,
  input  logic [PIX_W-1:0]  in_pixel_value,
  input  logic              cfg_we,
  input  logic [CFG_W-1:0]  cfg_wdata,
  output logic              out_strobe,
  output logic              out_result_kind,
  output logic [PIX_W-1:0]  out_corrected_pixel,
  output logic [ADDR_W-1:0] out_index,
  output logic              out_clipped,
  output logic [ADDR_W-1:0] out_dead_count
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_ACC, S_COR_MUL, S_COR_OUT,
    S_W_RD, S_W_DAT, S_W_GPRE, S_W_GDIV, S_W_MUL1, S_W_MUL2,
    S_W_OPRE, S_W_ODIV, S_W_WR
  } state_t;

  localparam int unsigned V_W   = 34;
  localparam int unsigned ODN_W = 35;

  state_t state_r;
  cmd_t   cmd_r;

  logic [ADDR_W-1:0] idx_r, walk_r, dead_r;
  logic              idx_ok_r;
  logic [PIX_W-1:0]  pix_r;
  logic [CFG_W-1:0]  frames_r;
  logic [TOT_W-1:0]  hot_tot_r, cold_tot_r, spread_r, den_r;
  logic [ODN_W-1:0]  oden_r;
  logic [SUM_W-1:0]  c_r;
  logic [GAIN_W-1:0] g_r;
  logic [OFF_W-1:0]  off_r;
  logic [37:0]       gc_r;
  logic [DIV_W-1:0]  gcp_r;
  logic              neg_r;
  logic signed [V_W-1:0] v_r;

  logic              out_strobe_r, out_kind_r, out_clip_r;
  logic [PIX_W-1:0]  out_pix_r;
  logic [ADDR_W-1:0] out_idx_r, out_dead_r;

  // memories
  logic [SUMS_W-1:0] sums_mem [NPIX];
  logic [COEF_W-1:0] coef_mem [NPIX];
  logic [SUMS_W-1:0] sums_rd_r, sums_wdata;
  logic [COEF_W-1:0] coef_rd_r, coef_wdata;
  logic [ADDR_W-1:0] raddr, sums_waddr, coef_waddr;
  logic              sums_we, coef_we;

  always_ff @(posedge clk) begin
    if (sums_we) sums_mem[sums_waddr] <= sums_wdata;
    sums_rd_r <= sums_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (coef_we) coef_mem[coef_waddr] <= coef_wdata;
    coef_rd_r <= coef_mem[raddr];
  end

  // divider
  logic             div_start, div_done;
  logic [DIV_W-1:0] div_num, div_den;
  logic [QUO_W-1:0] div_quo;

  nuc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // datapath
  logic              in_ok;
  logic [SUM_W-1:0]  h_rd, c_rd, s_sel, room, inc;
  logic [GAIN_W-1:0] g_rd;
  logic signed [OFF_W-1:0] o_rd;
  logic signed [V_W-1:0]   v_nxt;
  logic [DIV_W-1:0]  gnum, glim, onum, olim, mag;
  logic signed [DIV_W-1:0] a_val;
  logic [CFG_W-1:0]  f_eff;

  assign in_ok = (in_pixel_index < ADDR_W'(NPIX));
  assign h_rd  = sums_rd_r[SUMS_W-1:SUM_W];
  assign c_rd  = sums_rd_r[SUM_W-1:0];
  assign g_rd  = coef_rd_r[COEF_W-1:OFF_W];
  assign o_rd  = signed'(coef_rd_r[OFF_W-1:0]);
  assign s_sel = (cmd_r == CMD_HOT) ? h_rd : c_rd;
  assign room  = SUM_LIMIT - s_sel;
  assign inc   = (SUM_W'(pix_r) < room) ? SUM_W'(pix_r) : room;
  assign f_eff = (frames_r == '0) ? CFG_W'(1) : frames_r;

  always_comb begin
    logic [31:0] prod;
    logic [GAIN_W-1:0] g;
    logic signed [V_W-1:0] o;
    g     = idx_ok_r ? g_rd : UNITY_GAIN;
    o     = idx_ok_r ? V_W'(o_rd) : '0;
    prod  = 32'(g) * 32'(pix_r);
    v_nxt = signed'(V_W'(prod)) + (o <<< 8) + V_W'(2048);
  end

  assign gnum  = (DIV_W'(spread_r) << 12) + DIV_W'(den_r >> 1);
  assign glim  = DIV_W'(den_r) << GAIN_W;
  assign a_val = signed'(DIV_W'(cold_tot_r) << 12) - signed'(gcp_r);
  assign mag   = a_val[DIV_W-1] ? DIV_W'(-a_val) : DIV_W'(a_val);
  assign onum  = mag + DIV_W'(oden_r >> 1);
  assign olim  = DIV_W'(oden_r) << QUO_W;

  always_comb begin
    div_start = 1'b0;
    div_num   = gnum;
    div_den   = DIV_W'(den_r);
    if (state_r == S_W_GPRE) begin
      div_start = (gnum < glim);
    end else if (state_r == S_W_OPRE) begin
      div_start = (onum < olim);
      div_num   = onum;
      div_den   = DIV_W'(oden_r);
    end
  end

  // memory control
  always_comb begin
    raddr      = idx_r;
    sums_we    = 1'b0;
    sums_waddr = walk_r;
    sums_wdata = '0;
    coef_we    = 1'b0;
    coef_waddr = walk_r;
    coef_wdata = {UNITY_GAIN, {OFF_W{1'b0}}};
    case (state_r)
      S_IDLE: raddr = in_ok ? in_pixel_index : '0;
      S_W_RD: raddr = walk_r;
      S_CLR: begin
        sums_we = 1'b1;
        coef_we = 1'b1;
      end
      S_ACC: begin
        sums_we    = idx_ok_r;
        sums_waddr = idx_r;
        sums_wdata = (cmd_r == CMD_HOT) ? {h_rd + inc, c_rd} : {h_rd, c_rd + inc};
      end
      S_W_WR: begin
        sums_we    = 1'b1;
        coef_we    = 1'b1;
        coef_wdata = {g_r, off_r};
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      walk_r       <= '0;
      frames_r     <= RESET_FRAMES;
      hot_tot_r    <= '0;
      cold_tot_r   <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      if (cfg_we) frames_r <= cfg_wdata;
      case (state_r)
        S_CLR: begin
          walk_r <= walk_r + 1'b1;
          if (walk_r == ADDR_W'(NPIX - 1)) begin
            walk_r  <= '0;
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            cmd_r    <= cmd_t'(in_command);
            idx_r    <= in_pixel_index;
            idx_ok_r <= in_ok;
            pix_r    <= in_pixel_value;
            case (cmd_t'(in_command))
              CMD_HOT, CMD_COLD: state_r <= S_ACC;
              CMD_CORRECT:       state_r <= S_COR_MUL;
              default: begin
                walk_r   <= '0;
                dead_r   <= '0;
                spread_r <= (hot_tot_r > cold_tot_r) ? hot_tot_r - cold_tot_r : '0;
                oden_r   <= (ODN_W'(f_eff) * ODN_W'(NPIX)) << 8;
                state_r  <= S_W_RD;
              end
            endcase
          end
        end
        S_ACC: begin
          if (idx_ok_r) begin
            if (cmd_r == CMD_HOT) hot_tot_r <= hot_tot_r + TOT_W'(inc);
            else cold_tot_r <= cold_tot_r + TOT_W'(inc);
          end
          state_r <= S_IDLE;
        end
        S_COR_MUL: begin
          v_r     <= v_nxt;
          state_r <= S_COR_OUT;
        end
        S_COR_OUT: begin
          out_strobe_r <= 1'b1;
          out_kind_r   <= KIND_PIXEL;
          out_idx_r    <= idx_r;
          out_dead_r   <= '0;
          if (v_r[V_W-1]) begin
            out_pix_r  <= '0;
            out_clip_r <= 1'b1;
          end else if (|v_r[V_W-2:PIX_W+12]) begin
            out_pix_r  <= '1;
            out_clip_r <= 1'b1;
          end else begin
            out_pix_r  <= v_r[PIX_W+11:12];
            out_clip_r <= 1'b0;
          end
          state_r <= S_IDLE;
        end
        S_W_RD: state_r <= S_W_DAT;
        S_W_DAT: begin
          c_r   <= c_rd;
          den_r <= TOT_W'(h_rd - c_rd) * TOT_W'(NPIX);
          if (h_rd <= c_rd) begin
            dead_r  <= dead_r + 1'b1;
            g_r     <= UNITY_GAIN;
            off_r   <= '0;
            state_r <= S_W_WR;
          end else begin
            state_r <= S_W_GPRE;
          end
        end
        S_W_GPRE: begin
          if (gnum < glim) begin
            state_r <= S_W_GDIV;
          end else begin
            g_r     <= GAIN_MAX;
            state_r <= S_W_MUL1;
          end
        end
        S_W_GDIV: begin
          if (div_done) begin
            g_r     <= div_quo[GAIN_W-1:0];
            state_r <= S_W_MUL1;
          end
        end
        S_W_MUL1: begin
          gc_r    <= 38'(g_r) * 38'(c_r);
          state_r <= S_W_MUL2;
        end
        S_W_MUL2: begin
          gcp_r   <= DIV_W'(gc_r) * DIV_W'(NPIX);
          state_r <= S_W_OPRE;
        end
        S_W_OPRE: begin
          neg_r <= a_val[DIV_W-1];
          if (onum < olim) begin
            state_r <= S_W_ODIV;
          end else begin
            off_r   <= a_val[DIV_W-1] ? OFFSET_LOW : OFFSET_HIGH;
            state_r <= S_W_WR;
          end
        end
        S_W_ODIV: begin
          if (div_done) begin
            if (neg_r) begin
              off_r <= (div_quo > QUO_W'(OFFSET_LOW)) ? OFFSET_LOW : OFF_W'(-div_quo);
            end else begin
              off_r <= (div_quo > QUO_W'(OFFSET_HIGH)) ? OFFSET_HIGH : OFF_W'(div_quo);
            end
            state_r <= S_W_WR;
          end
        end
        S_W_WR: begin
          walk_r <= walk_r + 1'b1;
          if (walk_r == ADDR_W'(NPIX - 1)) begin
            hot_tot_r    <= '0;
            cold_tot_r   <= '0;
            out_strobe_r <= 1'b1;
            out_kind_r   <= KIND_CAL;
            out_pix_r    <= '0;
            out_idx_r    <= '0;
            out_clip_r   <= 1'b0;
            out_dead_r   <= dead_r;
            state_r      <= S_IDLE;
          end else begin
            state_r <= S_W_RD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy                = (state_r != S_IDLE);
  assign out_strobe          = out_strobe_r;
  assign out_result_kind     = out_kind_r;
  assign out_corrected_pixel = out_pix_r;
  assign out_index           = out_idx_r;
  assign out_clipped         = out_clip_r;
  assign out_dead_count      = out_dead_r;

endmodule

// File: rtl/nuc_chk.sv
`include "assert_macros.svh"

module nuc_chk
  import nuc_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_strobe,
  input logic              out_result_kind,
  input logic [PIX_W-1:0]  out_corrected_pixel,
  input logic [ADDR_W-1:0] out_index,
  input logic              out_clipped,
  input logic [ADDR_W-1:0] out_dead_count
);

  `NUC_ASSERT_NOW(a_cal_word_clean, out_strobe && out_result_kind == KIND_CAL,
    out_corrected_pixel == '0 && out_index == '0 && !out_clipped, "cal word has pixel data")
  `NUC_ASSERT_NOW(a_pix_no_dead, out_strobe && out_result_kind == KIND_PIXEL,
    out_dead_count == '0, "pixel word has dead count")
  `NUC_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
  `NUC_ASSERT_NEXT(a_single_strobe, out_strobe, !out_strobe, "back to back result words")

endmodule

bind two_point_nonuniformity_correction nuc_chk u_nuc_chk (.*);
